>>> rtl/sort_block_ascending_top_defines.svh
// Assertion macros shared by the sorter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef SORT_BLOCK_ASCENDING_TOP_DEFINES_SVH
`define SORT_BLOCK_ASCENDING_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define SBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sba_pkg.sv
// Shared types and constants for the ascending block sorter.
// No dependencies.
package sba_pkg;

    localparam int DEPTH = 64;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> rtl/sba_if.sv
// Valid/ready channel interfaces for the sorter input and result streams.
// Depends on sba_pkg.
interface sba_elem_if;
    import sba_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sba_sorted_if;
    import sba_pkg::*;

    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   final_res;
    logic   dropped;

    modport source (output valid, output sorted_value, output final_res,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input dropped, output ready);
endinterface

>>> rtl/sba_cell.sv
// One insertion cell of the sorting chain: holds one value.
// Depends on sba_pkg.
module sba_cell (
    input  logic               clk,
    input  sba_pkg::cell_ctrl_t ctrl,
    input  sba_pkg::value_t    ins_value,
    input  logic               occupied,
    input  logic               prev_gt,
    input  sba_pkg::value_t    prev_value,
    input  sba_pkg::value_t    next_value,
    output logic               gt,
    output sba_pkg::value_t    value
);
    import sba_pkg::*;

    value_t value_reg;
    value_t value_next;

    // Empty cells act as +infinity; equal values stay ahead of the new one.
    assign gt = !occupied || (value_reg > ins_value);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (prev_gt)
                value_next = prev_value;
            else if (gt)
                value_next = ins_value;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/sort_block_ascending_top.sv
// Top level of the ascending block sorter: controller plus chain of cells.
// Depends on sba_pkg, sba_if.sv, sba_cell and sort_block_ascending_top_defines.svh.
//
//  Channel | Modport | Payload                           | Transfer when
//  --------+---------+-----------------------------------+--------------------
//  elem    | sink    | value[31:0] signed, last          | valid && ready
//  sorted  | source  | sorted_value[31:0], final_res,    | valid && ready
//          |         | dropped                           |
//
// Fill: one element per cycle, inserted into the cell chain in one step
// (broadcast compare, each cell takes its left neighbor, the new value, or holds).
// Drain: after the element marked last, the chain shifts toward cell 0, one
// result per cycle while the sink is ready.
// No element is taken while a block drains; results are shown straight from
// cell 0 and hold while the sink stalls.
// Reset clears the fill count, the overflow flag and the controller state;
// cell contents need no reset, since only cells below the count are read.
module sort_block_ascending_top (
    input  logic              clk,
    input  logic              rst_n,
    sba_elem_if.sink          elem,
    sba_sorted_if.source      sorted
);
    import sba_pkg::*;
    `include "sort_block_ascending_top_defines.svh"

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    count_t     cnt_reg;
    count_t     cnt_next;
    logic       ovf_reg;
    logic       ovf_next;

    logic       in_xfer;
    logic       out_xfer;
    logic       full;
    cell_ctrl_t ctrl;

    logic   [DEPTH-1:0] occ;
    logic   [DEPTH-1:0] gt;
    value_t             cell_value [DEPTH];

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign in_xfer  = elem.valid && elem.ready;
    assign out_xfer = sorted.valid && sorted.ready;

    // Drop the element when the chain is full; it still closes the block.
    assign ctrl.insert = in_xfer && !full;
    assign ctrl.shift  = out_xfer;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_xfer)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        cnt_next = cnt_reg + 1'b1;
                    if (elem.last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_xfer)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_FILL;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Chain of cells: cell 0 holds the smallest value.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic   prev_gt;
        value_t prev_value;
        value_t next_value;

        assign occ[g] = (cnt_reg > CNT_W'(g));

        if (g == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
        end
        else
        begin : g_body
            assign prev_gt    = gt[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign next_value = '0;
        end
        else
        begin : g_mid
            assign next_value = cell_value[g+1];
        end

        sba_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_value  (elem.value),
            .occupied   (occ[g]),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .next_value (next_value),
            .gt         (gt[g]),
            .value      (cell_value[g])
        );
    end

    assign elem.ready          = (state_reg == ST_FILL);
    assign sorted.valid        = (state_reg == ST_DRAIN);
    assign sorted.sorted_value = cell_value[0];
    assign sorted.final_res    = (cnt_reg == CNT_W'(1));
    assign sorted.dropped      = ovf_reg;

    `SBA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SBA_ASSERT_NOW(a_drain_nonempty, state_reg == ST_DRAIN, cnt_reg != '0, "drain with empty chain")
    `SBA_ASSERT_NEXT(a_last_drains, in_xfer && elem.last, state_reg == ST_DRAIN, "last did not start drain")
    `SBA_ASSERT_NEXT(a_full_drop, in_xfer && full, ovf_reg, "drop not flagged")
    `SBA_ASSERT_NEXT(a_final_clears, out_xfer && sorted.final_res, (state_reg == ST_FILL) && !ovf_reg && (cnt_reg == '0), "block end did not clear")

endmodule

>>> test/sort_block_ascending_top_test.sv
// Self-checking testbench for the ascending block sorter (sort_block_ascending_top).
// Depends on sba_pkg and the channel interfaces in sba_if.sv; predicts results itself.
module sort_block_ascending_top_test;
    import sba_pkg::*;

    // One sorted result as it should leave the block.
    typedef struct packed {
        value_t sorted_value;
        logic   final_res;
        logic   dropped;
    } sorted_res_t;

    // One row of the directed table. Rows with a typed result carry it in want;
    // the rest are checked against the predictor.
    typedef struct packed {
        value_t      value;
        logic        last;
        logic        typed;
        sorted_res_t want;
    } stim_row_t;

    localparam value_t VMAX = 32'sh7FFF_FFFF;
    localparam value_t VMIN = 32'sh8000_0000;
    localparam value_t VNEG = -32'sd1;

    localparam int IDLE_LIMIT = 2000;
    localparam int DIR_ROWS   = 20;

    localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // single-element blocks: the element comes straight back, marked final
        '{32'sh0000_0000, 1'b1, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
        '{VMAX,           1'b1, 1'b1, '{VMAX,           1'b1, 1'b0}},
        '{VMIN,           1'b1, 1'b1, '{VMIN,           1'b1, 1'b0}},
        '{VNEG,           1'b1, 1'b1, '{VNEG,           1'b1, 1'b0}},
        // both extremes, the sign boundary and alternating bit patterns
        '{VMAX,           1'b0, 1'b0, '0},
        '{VMIN,           1'b0, 1'b0, '0},
        '{VNEG,           1'b0, 1'b0, '0},
        '{32'sh0000_0000, 1'b0, 1'b0, '0},
        '{32'sh0000_0001, 1'b0, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0, '0},
        // strictly descending block
        '{32'sh0000_0003, 1'b0, 1'b0, '0},
        '{32'sh0000_0002, 1'b0, 1'b0, '0},
        '{32'sh0000_0001, 1'b0, 1'b0, '0},
        '{VNEG,           1'b1, 1'b0, '0},
        // repeated values, including a repeated minimum at the end
        '{32'sh0000_0007, 1'b0, 1'b0, '0},
        '{-32'sd7,        1'b0, 1'b0, '0},
        '{32'sh0000_0007, 1'b0, 1'b0, '0},
        '{VMIN,           1'b0, 1'b0, '0},
        '{VMIN,           1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;    // high: neither side idles

    sba_elem_if   elem_ch ();
    sba_sorted_if res_ch ();

    sort_block_ascending_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_ch),
        .sorted (res_ch)
    );

    always #5 clk = ~clk;

    // Predictor state: the elements held so far in this block, in order of
    // arrival, and whether any element of the block was discarded.
    value_t      held_values [$];
    logic        held_overflow = 1'b0;
    sorted_res_t sorted_expect [$];

    int elems_sent      = 0;
    int blocks_closed   = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    // Draw an element value: mostly full-range, with extremes and a narrow
    // band near zero so that blocks contain repeated values.
    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return VMAX;
            1:       return VMIN;
            2, 3:    return value_t'(int'($urandom_range(0, 8)) - 4);
            default: return value_t'($urandom);
        endcase
    endfunction

    // Offer one element, hold it until the transfer, then update the predictor.
    // A typed row supplies its own expected result in place of the predicted one.
    task automatic send_elem(input value_t v, input logic l, input logic typed,
                             input sorted_res_t want);
        value_t work [$];
        int     j;
        elem_ch.valid <= 1'b1;
        elem_ch.value <= v;
        elem_ch.last  <= l;
        @(posedge clk);
        while (!elem_ch.ready)
            @(posedge clk);
        elems_sent++;

        // Store while there is room, otherwise drop and remember the drop.
        if (held_values.size() < DEPTH)
            held_values.push_back(v);
        else
            held_overflow = 1'b1;

        if (l) begin
            // Stable insertion: a new element moves only past strictly greater ones.
            foreach (held_values[i]) begin
                j = work.size();
                while (j > 0 && work[j-1] > held_values[i])
                    j--;
                work.insert(j, held_values[i]);
            end
            if (typed)
                sorted_expect.push_back(want);
            else
                foreach (work[i])
                    sorted_expect.push_back('{sorted_value: work[i],
                                              final_res: (i == work.size() - 1),
                                              dropped: held_overflow});
            held_values.delete();
            held_overflow = 1'b0;
            blocks_closed++;
        end

        // Idle the source now and then, for a geometric number of cycles.
        if (!steady && $urandom_range(0, 99) < 13) begin
            elem_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 13);
        end
    endtask

    // Stall the result side at random, about 13 percent of the time, except while steady.
    always @(posedge clk)
        res_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= 13);

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Compare every result transfer with the oldest pending expectation.
    always @(posedge clk) begin : check_results
        sorted_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (sorted_expect.size() == 0) begin
                $error("sorted_value: expected none, got 0x%08h", res_ch.sorted_value);
                mismatches++;
            end else begin
                want = sorted_expect.pop_front();
                check_field("sorted_value", want.sorted_value, res_ch.sorted_value);
                check_field("final_res", 32'(want.final_res), 32'(res_ch.final_res));
                check_field("dropped", 32'(want.dropped), 32'(res_ch.dropped));
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when neither channel has moved for too long.
    always @(posedge clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int b;
        int n;
        int k;
        int random_elems;
        rst_n         = 1'b0;
        elem_ch.valid = 1'b0;
        elem_ch.value = '0;
        elem_ch.last  = 1'b0;
        res_ch.ready  = 1'b0;
        random_elems  = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: extremes, single elements, descending and repeated values.
        for (k = 0; k < DIR_ROWS; k++)
            send_elem(DIRECTED[k].value, DIRECTED[k].last, DIRECTED[k].typed,
                      DIRECTED[k].want);

        // Random blocks, mostly short. Block 3 overruns the store by two with no
        // idling on either side: the store fills exactly, then both a plain
        // element and the closing element are dropped.
        for (b = 0; b < 6 || random_elems < 110; b++) begin
            if (b == 3)
                n = DEPTH + 2;
            else
                n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 6);
            steady <= (b == 3 || b == 4);
            for (k = 0; k < n; k++)
                send_elem(pick_value(), k == n - 1, 1'b0, '0);
            random_elems += n;
        end
        elem_ch.valid <= 1'b0;
        steady        <= 1'b0;

        // Drain what is still expected, then watch for strays for a full block.
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 16)
            @(posedge clk);

        $display("sorted %0d blocks from %0d elements, %0d results compared",
                 blocks_closed, elems_sent, results_checked);
        $display("covered extremes, repeats, a full store and an overrun with drops");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sba_pkg.sv
rtl/sba_if.sv
rtl/sba_cell.sv
rtl/sort_block_ascending_top.sv
test/sort_block_ascending_top_test.sv
